// ----- hdl/lefjs_pkg.sv -----
package lefjs_pkg;

  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = 6;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  typedef logic signed [31:0] fx_t;

  localparam fx_t SAT_MAX = 32'sh7fffffff;
  localparam fx_t SAT_MIN = 32'sh80000000;

  localparam logic [1:0] REG_MEAN_U = 2'd0;
  localparam logic [1:0] REG_MEAN_V = 2'd1;
  localparam logic [1:0] REG_SOUND  = 2'd2;

  localparam logic [2:0] LAST_SLOT = 3'd7;

  typedef enum logic [1:0] {RCP_IDLE, RCP_DIV1, RCP_DIV2} rcp_state_t;

  // one queued face: normal, normal velocity and the two acoustic eigenvalues
  typedef struct packed {
    fx_t nx;
    fx_t ny;
    fx_t vn;
    fx_t lam_p;
    fx_t lam_m;
  } ent_t;

  typedef struct packed {
    logic busy;
    fx_t  inv_c;
    fx_t  inv_c2;
  } rcp_stat_t;

  function automatic fx_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return SAT_MAX;
    end else if (x < -64'sd2147483648) begin
      return SAT_MIN;
    end
    return x[31:0];
  endfunction

  // round half up, then drop the fraction bits of a product
  function automatic logic signed [63:0] fx_rnd(input logic signed [63:0] p,
                                                input int unsigned fb);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< (fb - 1);
    return (p + bias) >>> fb;
  endfunction

  function automatic fx_t fx_neg(input fx_t x);
    if (x == SAT_MIN) begin
      return SAT_MAX;
    end
    return -x;
  endfunction

  // multiply by 0.5 with round half up: floor((x+1)/2)
  function automatic fx_t fx_half(input fx_t x);
    logic signed [32:0] t;
    t = 33'(x) + 33'sd1;
    return t[32:1];
  endfunction

endpackage

// ----- hdl/lefjs_recip.sv -----
module lefjs_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [30:0]          c_new,
  output lefjs_pkg::rcp_stat_t stat
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  lefjs_pkg::rcp_state_t state_r, state_nxt;
  logic [lefjs_pkg::DIV_W-1:0]     num_r, num_nxt;
  logic [lefjs_pkg::DIV_W-1:0]     q_r, q_nxt;
  logic [31:0]                     rem_r, rem_nxt;
  logic [30:0]                     den_r, den_nxt;
  logic [lefjs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]                     ic_r, ic_nxt, ic2_r, ic2_nxt;
  logic [31:0]                     rem_sh, qsat;
  logic [lefjs_pkg::DIV_W-1:0]     q_step;
  logic                            ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lefjs_pkg::RCP_IDLE;
      ic_r    <= ONE;
      ic2_r   <= ONE;
    end else begin
      state_r <= state_nxt;
      ic_r    <= ic_nxt;
      ic2_r   <= ic2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  // one restoring-division bit per cycle; a zero divisor gives all ones and saturates
  always_comb begin
    rem_sh = {rem_r[30:0], num_r[lefjs_pkg::DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    q_step = {q_r[lefjs_pkg::DIV_W-2:0], ge};
    qsat   = (|q_step[lefjs_pkg::DIV_W-1:31]) ? 32'h7fffffff : q_step[31:0];

    state_nxt = state_r;
    num_nxt   = num_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    ic_nxt    = ic_r;
    ic2_nxt   = ic2_r;

    case (state_r)
      lefjs_pkg::RCP_IDLE: begin
      end
      lefjs_pkg::RCP_DIV1, lefjs_pkg::RCP_DIV2: begin
        num_nxt = num_r << 1;
        q_nxt   = q_step;
        rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lefjs_pkg::DIV_CNT_W'(lefjs_pkg::DIV_W - 1)) begin
          if (state_r == lefjs_pkg::RCP_DIV1) begin
            ic_nxt    = qsat;
            num_nxt   = ({32'd0, qsat} << FRAC_BITS) + {33'd0, den_r[30:1]};
            q_nxt     = '0;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = lefjs_pkg::RCP_DIV2;
          end else begin
            ic2_nxt   = qsat;
            state_nxt = lefjs_pkg::RCP_IDLE;
          end
        end
      end
      default: state_nxt = lefjs_pkg::RCP_IDLE;
    endcase

    // a new sound speed restarts the whole reciprocal pass
    if (start) begin
      state_nxt = lefjs_pkg::RCP_DIV1;
      den_nxt   = c_new;
      num_nxt   = (64'd1 << (2 * FRAC_BITS)) + {33'd0, c_new[30:1]};
      q_nxt     = '0;
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  assign stat.busy   = (state_r != lefjs_pkg::RCP_IDLE);
  assign stat.inv_c  = ic_r;
  assign stat.inv_c2 = ic2_r;

endmodule

// ----- hdl/lefjs_front.sv -----
module lefjs_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lefjs_pkg::fx_t  nx,
  input  lefjs_pkg::fx_t  ny,
  input  logic            busy,
  input  lefjs_pkg::fx_t  mean_u,
  input  lefjs_pkg::fx_t  mean_v,
  input  logic [30:0]     c,
  input  logic            q_full,
  output logic            push,
  output lefjs_pkg::ent_t ent
);

  logic           s0_v_r, s1_v_r;
  lefjs_pkg::fx_t nx0_r, ny0_r, nx1_r, ny1_r, vn;
  logic signed [63:0] pu_r, pv_r, pu_nxt, pv_nxt;
  logic           s0_go, s1_go, in_fire;

  assign push     = s1_v_r && !q_full;
  assign s1_go    = !s1_v_r || !q_full;
  assign s0_go    = !s0_v_r || s1_go;
  assign in_ready = s0_go && !busy;
  assign in_fire  = in_valid && in_ready;

  assign pu_nxt = mean_u * nx0_r;
  assign pv_nxt = mean_v * ny0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (s0_go) s0_v_r <= in_fire;
      if (s1_go) s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      nx0_r <= nx;
      ny0_r <= ny;
    end
    if (s1_go) begin
      nx1_r <= nx0_r;
      ny1_r <= ny0_r;
      pu_r  <= pu_nxt;
      pv_r  <= pv_nxt;
    end
  end

  assign vn = lefjs_pkg::sat32(lefjs_pkg::fx_rnd(pu_r, FRAC_BITS) +
                               lefjs_pkg::fx_rnd(pv_r, FRAC_BITS));

  assign ent.nx    = nx1_r;
  assign ent.ny    = ny1_r;
  assign ent.vn    = vn;
  assign ent.lam_p = lefjs_pkg::sat32(64'(vn) + {33'd0, c});
  assign ent.lam_m = lefjs_pkg::sat32(64'(vn) - {33'd0, c});

endmodule

// ----- hdl/lefjs_queue.sv -----
module lefjs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lefjs_pkg::ent_t wr_ent,
  input  logic            pop,
  output lefjs_pkg::ent_t rd_ent,
  output logic            empty,
  output logic            full
);

  lefjs_pkg::ent_t              mem_r [lefjs_pkg::QDEPTH];
  logic [lefjs_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [lefjs_pkg::QPTR_W:0]   cnt_r;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (lefjs_pkg::QPTR_W + 1)'(lefjs_pkg::QDEPTH));
  assign rd_ent = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{lefjs_pkg::QPTR_W{1'b0}}, push} - {{lefjs_pkg::QPTR_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_ent;
  end

endmodule

// ----- hdl/lefjs_back.sv -----
module lefjs_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lefjs_pkg::ent_t      head,
  input  logic                 q_empty,
  output logic                 pop,
  input  lefjs_pkg::rcp_stat_t rstat,
  input  logic [30:0]          c,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lefjs_pkg::fx_t       col [4],
  output lefjs_pkg::fx_t       eig,
  output logic                 minus,
  output logic [1:0]           row,
  output logic                 last
);

  localparam lefjs_pkg::fx_t ONE = 32'sd1 <<< FRAC_BITS;

  logic en, issue;
  logic [2:0] cnt_r;

  // stage A: split eigenvalues times L
  logic               a_v_r;
  logic signed [63:0] tp_r [4][4], tp_nxt [4][4];
  lefjs_pkg::fx_t     ra_r [4], rrow [4];
  lefjs_pkg::fx_t     a_eig_r;
  logic [2:0]         a_slot_r;
  // stage B: saturated T
  logic               b_v_r;
  lefjs_pkg::fx_t     t_r [4][4], rb_r [4];
  lefjs_pkg::fx_t     b_eig_r;
  logic [2:0]         b_slot_r;
  // stage C: R row times T
  logic               c_v_r;
  logic signed [63:0] jp_r [4][4];
  lefjs_pkg::fx_t     c_eig_r;
  logic [2:0]         c_slot_r;
  // output register
  logic               o_v_r;
  lefjs_pkg::fx_t     o_col_r [4], col_nxt [4];
  lefjs_pkg::fx_t     o_eig_r;
  logic [2:0]         o_slot_r;

  lefjs_pkg::fx_t lam [4], e [4], lm [4][4];
  lefjs_pkg::fx_t hnx, hny;
  logic signed [63:0] acc;

  assign en    = !o_v_r || out_ready;
  assign issue = en && !q_empty;
  assign pop   = issue && (cnt_r == lefjs_pkg::LAST_SLOT);

  always_comb begin
    hnx = lefjs_pkg::fx_half(head.nx);
    hny = lefjs_pkg::fx_half(head.ny);
    lam[0] = head.vn;
    lam[1] = head.vn;
    lam[2] = head.lam_p;
    lam[3] = head.lam_m;
    for (int k = 0; k < 4; k++) begin
      if (cnt_r[2]) e[k] = (lam[k] < 0) ? lam[k] : '0;
      else          e[k] = (lam[k] > 0) ? lam[k] : '0;
    end
    lm[0][0] = ONE; lm[0][1] = '0; lm[0][2] = '0;
    lm[0][3] = lefjs_pkg::fx_neg(rstat.inv_c2);
    lm[1][0] = '0; lm[1][1] = head.ny; lm[1][2] = lefjs_pkg::fx_neg(head.nx); lm[1][3] = '0;
    lm[2][0] = '0; lm[2][1] = head.nx; lm[2][2] = head.ny; lm[2][3] = rstat.inv_c;
    lm[3][0] = '0; lm[3][1] = lefjs_pkg::fx_neg(head.nx);
    lm[3][2] = lefjs_pkg::fx_neg(head.ny); lm[3][3] = rstat.inv_c;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        tp_nxt[k][j] = e[k] * lm[k][j];
      end
    end
    case (cnt_r[1:0])
      2'd0: begin
        rrow[0] = ONE; rrow[1] = '0;
        rrow[2] = lefjs_pkg::fx_half(rstat.inv_c); rrow[3] = lefjs_pkg::fx_half(rstat.inv_c);
      end
      2'd1: begin
        rrow[0] = '0; rrow[1] = head.ny; rrow[2] = hnx; rrow[3] = lefjs_pkg::fx_neg(hnx);
      end
      2'd2: begin
        rrow[0] = '0; rrow[1] = lefjs_pkg::fx_neg(head.nx);
        rrow[2] = hny; rrow[3] = lefjs_pkg::fx_neg(hny);
      end
      default: begin
        rrow[0] = '0; rrow[1] = '0;
        rrow[2] = lefjs_pkg::fx_half({1'b0, c}); rrow[3] = lefjs_pkg::fx_half({1'b0, c});
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + lefjs_pkg::fx_rnd(jp_r[k][j], FRAC_BITS);
      end
      col_nxt[j] = lefjs_pkg::sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      if (issue) cnt_r <= cnt_r + 1'b1;
      a_v_r <= issue;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      o_v_r <= c_v_r;
    end
  end

  // hold every stage while the output item waits
  always_ff @(posedge clk) begin
    if (en) begin
      tp_r     <= tp_nxt;
      ra_r     <= rrow;
      a_eig_r  <= lam[cnt_r[1:0]];
      a_slot_r <= cnt_r;
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          t_r[k][j]  <= lefjs_pkg::sat32(lefjs_pkg::fx_rnd(tp_r[k][j], FRAC_BITS));
          jp_r[k][j] <= rb_r[k] * t_r[k][j];
        end
      end
      rb_r     <= ra_r;
      b_eig_r  <= a_eig_r;
      b_slot_r <= a_slot_r;
      c_eig_r  <= b_eig_r;
      c_slot_r <= b_slot_r;
      o_col_r  <= col_nxt;
      o_eig_r  <= c_eig_r;
      o_slot_r <= c_slot_r;
    end
  end

  assign out_valid = o_v_r;
  assign col       = o_col_r;
  assign eig       = o_eig_r;
  assign minus     = o_slot_r[2];
  assign row       = o_slot_r[1:0];
  assign last      = (o_slot_r == lefjs_pkg::LAST_SLOT);

endmodule

// ----- hdl/linearized_euler_flux_jacobian_split_unit.sv -----
// Split flux Jacobians of the 2D linearized Euler equations for one face normal.
// Each accepted normal (nx, ny) yields eight row items: four rows of J+ then four
// rows of J-, with tlast on the eighth. Values are Q(FRAC_BITS) signed fixed point
// in 32 bits and saturate. The result channel carries one row per cycle while
// out_tready is high and a normal is queued; an accepted normal passes the front
// stage registers, the queue and stages A, B and C to the output register. Writing
// sound_speed starts a bit-serial reciprocal pass (two 64-step divisions) for 1/c
// and 1/c^2; in_tready stays low until it ends.
module linearized_euler_flux_jacobian_split_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // normal_x, normal_y
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [159:0]  out_tdata,  // col_zero, col_one, col_two, col_three, eigen_value
  output logic [2:0]    out_tuser,  // minus_part, row_index
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  lefjs_pkg::fx_t       mean_u_r, mean_v_r;
  logic [30:0]          sound_r;
  logic                 cfg_fire, c_wr;
  lefjs_pkg::rcp_stat_t rstat;
  lefjs_pkg::ent_t      f_ent, q_ent;
  logic                 push, pop, q_empty, q_full;
  lefjs_pkg::fx_t       col [4];
  lefjs_pkg::fx_t       eig;
  logic                 minus, last;
  logic [1:0]           row;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign c_wr      = cfg_fire && (cfg_index == lefjs_pkg::REG_SOUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_u_r <= '0;
      mean_v_r <= '0;
      sound_r  <= 31'd1 << FRAC_BITS;
    end else if (cfg_fire) begin
      case (cfg_index)
        lefjs_pkg::REG_MEAN_U: mean_u_r <= cfg_data;
        lefjs_pkg::REG_MEAN_V: mean_v_r <= cfg_data;
        lefjs_pkg::REG_SOUND:  sound_r  <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  lefjs_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_wr),
    .c_new (cfg_data[30:0]),
    .stat  (rstat)
  );

  lefjs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .nx       (in_tdata[31:0]),
    .ny       (in_tdata[63:32]),
    .busy     (rstat.busy),
    .mean_u   (mean_u_r),
    .mean_v   (mean_v_r),
    .c        (sound_r),
    .q_full   (q_full),
    .push     (push),
    .ent      (f_ent)
  );

  lefjs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_ent (f_ent),
    .pop    (pop),
    .rd_ent (q_ent),
    .empty  (q_empty),
    .full   (q_full)
  );

  lefjs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_ent),
    .q_empty   (q_empty),
    .pop       (pop),
    .rstat     (rstat),
    .c         (sound_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .col       (col),
    .eig       (eig),
    .minus     (minus),
    .row       (row),
    .last      (last)
  );

  assign out_tdata = {eig, col[3], col[2], col[1], col[0]};
  assign out_tuser = {row, minus};
  assign out_tlast = last;

endmodule

// ----- hdl/lefjs_check.sv -----
module lefjs_check (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  // hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 3'b111)))
    else $error("tlast not on final row of J-");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // rows follow in order within a frame
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid
      |-> out_tuser == $past(out_tuser) + 3'd2 || out_tuser == ($past(out_tuser) ^ 3'b111))
    else $error("result rows out of order");

endmodule

bind linearized_euler_flux_jacobian_split_unit lefjs_check u_chk (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MAX = -64'sd2147483648;

  typedef enum logic {OP_ITEM, OP_CFG} step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [1:0] idx;
    logic [31:0] data;
    lefjs_pkg::fx_t nx;
    lefjs_pkg::fx_t ny;
    bit typed;
    lefjs_pkg::fx_t typed_c3;
  } step_t;

  typedef struct {
    lefjs_pkg::fx_t col0;
    lefjs_pkg::fx_t col1;
    lefjs_pkg::fx_t col2;
    lefjs_pkg::fx_t col3;
    lefjs_pkg::fx_t eig;
    logic minus;
    logic [1:0] row;
    logic last;
  } face_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  longint mean_u_q = 0;
  longint mean_v_q = 0;
  longint sound_q = ONE;
  face_row_t jac_rows_due[$];
  step_t steps[$];
  int errors = 0;
  int burst_left = 0;
  logic [7:0] stall_pat = 8'hff;
  int pat_age = 0;
  logic [2:0] pat_ptr = '0;

  linearized_euler_flux_jacobian_split_unit #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clamp32(longint x);
    if (x > POS_MAX) return POS_MAX;
    if (x < NEG_MAX) return NEG_MAX;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return (p + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint qneg(longint x);
    return clamp32(-x);
  endfunction

  function automatic longint recip_div(longint num, longint den);
    longint q;
    if (den == 0) return POS_MAX;
    q = (num + den / 2) / den;
    return (q > POS_MAX) ? POS_MAX : q;
  endfunction

  // expected eight rows of J+ and J- for one face normal
  function automatic void predict_split_rows(lefjs_pkg::fx_t nx_i, lefjs_pkg::fx_t ny_i);
    longint nx, ny, c, inv_c, inv_c2, vn, acc;
    longint lam[4], e[4];
    longint rm[4][4], lm[4][4], t[4][4];
    longint cols[4];
    face_row_t r;
    nx = nx_i;
    ny = ny_i;
    c = sound_q;
    inv_c = recip_div(64'sd1 <<< (2 * FB), c);
    inv_c2 = recip_div(inv_c <<< FB, c);
    vn = clamp32(qmul(mean_u_q, nx) + qmul(mean_v_q, ny));
    lam[0] = vn;
    lam[1] = vn;
    lam[2] = clamp32(vn + c);
    lam[3] = clamp32(vn - c);
    rm[0] = '{ONE, 0, qmul(ONE / 2, inv_c), qmul(ONE / 2, inv_c)};
    rm[1] = '{0, ny, qmul(ONE / 2, nx), qneg(qmul(ONE / 2, nx))};
    rm[2] = '{0, qneg(nx), qmul(ONE / 2, ny), qneg(qmul(ONE / 2, ny))};
    rm[3] = '{0, 0, qmul(ONE / 2, c), qmul(ONE / 2, c)};
    lm[0] = '{ONE, 0, 0, qneg(inv_c2)};
    lm[1] = '{0, ny, qneg(nx), 0};
    lm[2] = '{0, nx, ny, inv_c};
    lm[3] = '{0, qneg(nx), qneg(ny), inv_c};
    for (int part = 0; part < 2; part++) begin
      for (int k = 0; k < 4; k++) begin
        if (part == 0) e[k] = (lam[k] > 0) ? lam[k] : 0;
        else e[k] = (lam[k] < 0) ? lam[k] : 0;
        for (int j = 0; j < 4; j++) t[k][j] = clamp32(qmul(e[k], lm[k][j]));
      end
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += qmul(rm[i][k], t[k][j]);
          cols[j] = clamp32(acc);
        end
        r.col0 = lefjs_pkg::fx_t'(cols[0]);
        r.col1 = lefjs_pkg::fx_t'(cols[1]);
        r.col2 = lefjs_pkg::fx_t'(cols[2]);
        r.col3 = lefjs_pkg::fx_t'(cols[3]);
        r.eig = lefjs_pkg::fx_t'(lam[i]);
        r.minus = logic'(part);
        r.row = 2'(i);
        r.last = (part == 1 && i == 3);
        jac_rows_due.push_back(r);
      end
    end
  endfunction

  function automatic void add_item(lefjs_pkg::fx_t nx, lefjs_pkg::fx_t ny, bit typed = 0,
                                   lefjs_pkg::fx_t c3 = '0);
    step_t s;
    s = '{OP_ITEM, 2'd0, 32'd0, nx, ny, typed, c3};
    steps.push_back(s);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [31:0] data);
    step_t s;
    s = '{OP_CFG, idx, data, '0, '0, 0, '0};
    steps.push_back(s);
  endfunction

  function automatic lefjs_pkg::fx_t rand_normal();
    if ($urandom_range(0, 6) == 0) return lefjs_pkg::fx_t'($urandom);
    return lefjs_pkg::fx_t'(int'($urandom_range(0, 2 * 65536)) - 65536);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lefjs_pkg::REG_MEAN_U: mean_u_q = longint'(signed'(data));
      lefjs_pkg::REG_MEAN_V: mean_v_q = longint'(signed'(data));
      lefjs_pkg::REG_SOUND: sound_q = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  // hold valid across back-to-back items; drop it only for a gap
  task automatic send_normal(lefjs_pkg::fx_t nx, lefjs_pkg::fx_t ny, bit typed,
                             lefjs_pkg::fx_t c3);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ny, nx};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    predict_split_rows(nx, ny);
    if (typed) jac_rows_due[$].col3 = c3;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (jac_rows_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (pat_age == 0) begin
      stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      pat_age <= $urandom_range(20, 200);
    end else begin
      pat_age <= pat_age - 1;
    end
    pat_ptr <= pat_ptr + 3'd1;
    out_tready <= rst_n ? stall_pat[pat_ptr] : 1'b0;
  end

  always @(posedge clk) begin
    face_row_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (jac_rows_due.size() == 0) begin
        $error("row item with nothing expected");
        errors++;
      end else begin
        w = jac_rows_due.pop_front();
        if (out_tdata[31:0] !== w.col0) begin
          $error("col_zero exp %0d got %0d", w.col0, $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tdata[63:32] !== w.col1) begin
          $error("col_one exp %0d got %0d", w.col1, $signed(out_tdata[63:32]));
          errors++;
        end
        if (out_tdata[95:64] !== w.col2) begin
          $error("col_two exp %0d got %0d", w.col2, $signed(out_tdata[95:64]));
          errors++;
        end
        if (out_tdata[127:96] !== w.col3) begin
          $error("col_three exp %0d got %0d", w.col3, $signed(out_tdata[127:96]));
          errors++;
        end
        if (out_tdata[159:128] !== w.eig) begin
          $error("eigen_value exp %0d got %0d", w.eig, $signed(out_tdata[159:128]));
          errors++;
        end
        if (out_tuser[0] !== w.minus) begin
          $error("minus_part exp %0d got %0d", w.minus, out_tuser[0]);
          errors++;
        end
        if (out_tuser[2:1] !== w.row) begin
          $error("row_index exp %0d got %0d", w.row, out_tuser[2:1]);
          errors++;
        end
        if (out_tlast !== w.last) begin
          $error("last_row exp %0d got %0d", w.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] cv;
    // after reset, zero normal: last J- row ends in -0.5
    add_item(32'sd0, 32'sd0, 1, -32'sd32768);
    add_item(32'sd65536, 32'sd0);
    add_item(32'sd0, 32'sd65536);
    add_item(lefjs_pkg::SAT_MAX, lefjs_pkg::SAT_MIN);
    add_item(lefjs_pkg::SAT_MIN, lefjs_pkg::SAT_MIN);
    add_item(lefjs_pkg::SAT_MAX, lefjs_pkg::SAT_MAX);
    add_item(-32'sd46341, 32'sd46341);
    add_cfg(lefjs_pkg::REG_MEAN_U, 32'h7fffffff);
    add_cfg(lefjs_pkg::REG_MEAN_V, 32'h80000000);
    add_item(32'sd65536, 32'sd0);
    add_item(lefjs_pkg::SAT_MAX, lefjs_pkg::SAT_MIN);
    add_cfg(lefjs_pkg::REG_MEAN_U, 32'h0000_8000);
    add_cfg(lefjs_pkg::REG_MEAN_V, 32'hffff_4000);
    add_cfg(lefjs_pkg::REG_SOUND, 32'h0000_0001);
    add_item(32'sd65536, 32'sd0);
    add_item(-32'sd65536, 32'sd65536);
    add_cfg(lefjs_pkg::REG_SOUND, 32'h0000_0000);
    add_item(32'sd0, -32'sd65536);
    add_cfg(lefjs_pkg::REG_SOUND, 32'hffff_ffff);
    add_cfg(lefjs_pkg::REG_MEAN_U, 32'h80000000);
    add_cfg(lefjs_pkg::REG_MEAN_V, 32'h7fffffff);
    add_item(32'sd46341, -32'sd46341);
    add_item(lefjs_pkg::SAT_MIN, lefjs_pkg::SAT_MAX);
    add_cfg(lefjs_pkg::REG_SOUND, 32'h0001_8000);
    add_item(32'sd65536, 32'sd65536);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    foreach (steps[n]) begin
      if (steps[n].kind == OP_CFG) begin
        settle();
        write_reg(steps[n].idx, steps[n].data);
      end else begin
        send_normal(steps[n].nx, steps[n].ny, steps[n].typed, steps[n].typed_c3);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      for (int r = 0; r < 3; r++) begin
        if (r == 2) begin
          case ($urandom_range(0, 5))
            0: cv = $urandom_range(1, 64);
            1: cv = $urandom;
            default: cv = $urandom_range(6554, 4 * 65536);
          endcase
        end else if ($urandom_range(0, 3) == 0) begin
          cv = $urandom;
        end else begin
          cv = 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
        end
        write_reg(2'(r), cv);
      end
      repeat (44) send_normal(rand_normal(), rand_normal(), 0, '0);
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lefjs_pkg.sv
hdl/lefjs_recip.sv
hdl/lefjs_front.sv
hdl/lefjs_queue.sv
hdl/lefjs_back.sv
hdl/linearized_euler_flux_jacobian_split_unit.sv
hdl/lefjs_check.sv
dv/tb.sv
